### rtl/core/pulse_width_register_write_tx_assert.svh
// ----------------------------------------------------------------------------
// Pulse-width register write transmitter assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_REGISTER_WRITE_TX_ASSERT_SVH
`define PULSE_WIDTH_REGISTER_WRITE_TX_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define PWRW_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PWRW_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PWRW_ASSERT_IMP(name, clk, rstn, ante, cons, msg)
`define PWRW_ASSERT_NXT(name, clk, rstn, ante, cons, msg)
`endif

`endif

### rtl/core/pwrw_pkg.sv
// ----------------------------------------------------------------------------
// Pulse-width register write transmitter package
// Shared types, register codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package pwrw_pkg;

  localparam int unsigned WordBits = 24;
  localparam int unsigned BitIdxW  = 5;
  localparam int unsigned CntW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEV_ADDR = 3'd0,
    CFG_PILOT    = 3'd1,
    CFG_ZERO     = 3'd2,
    CFG_ONE      = 3'd3,
    CFG_SPACE    = 3'd4,
    CFG_STOP     = 3'd5,
    CFG_PRE      = 3'd6,
    CFG_POST     = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_NONE      = 2'd0,
    REQ_ACCEPTED  = 2'd1,
    REQ_REF_AUDIO = 2'd2,
    REQ_REF_BUSY  = 2'd3
  } req_status_e;

  typedef struct packed {
    logic [6:0]      dev_addr;
    logic [CntW-1:0] pilot;
    logic [CntW-1:0] zero;
    logic [CntW-1:0] one;
    logic [CntW-1:0] space;
    logic [CntW-1:0] stop;
    logic [CntW-1:0] pre;
    logic [CntW-1:0] post;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    dev_addr: 7'h53,
    pilot:    8'd10,
    zero:     8'd10,
    one:      8'd30,
    space:    8'd10,
    stop:     8'd130,
    pre:      8'd60,
    post:     8'd60
  };

  typedef struct packed {
    logic       cmd;
    logic [7:0] reg_address;
    logic [7:0] reg_value;
    logic       audio_active;
  } item_t;

  typedef struct packed {
    logic        select_level;
    logic        clock_pulse;
    logic        busy_res;
    req_status_e request_status;
    logic        write_done;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/pwrw_if.sv
// ----------------------------------------------------------------------------
// Pulse-width register write transmitter channels
// Valid/ready word channels for commands and per-tick results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwrw_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] reg_address;
  logic [7:0] reg_value;
  logic       audio_active;

  modport source (output valid, cmd, reg_address, reg_value, audio_active, input ready);
  modport sink   (input valid, cmd, reg_address, reg_value, audio_active, output ready);
endinterface

interface pwrw_out_if;
  logic       valid;
  logic       ready;
  logic       select_level;
  logic       clock_pulse;
  logic       busy_res;
  logic [1:0] request_status;
  logic       write_done;

  modport source (output valid, select_level, clock_pulse, busy_res, request_status,
                  write_done, input ready);
  modport sink   (input valid, select_level, clock_pulse, busy_res, request_status,
                  write_done, output ready);
endinterface

`default_nettype wire

### rtl/core/pulse_width_register_write_tx.sv
// Takes one command word per clock cycle, back to back, while the result side
// drains, and returns one result word for each through the input register and
// then the result register, with all phase, counter and shift-word updates made
// in the single pass between them. Each tick word advances the waveform by one
// serial clock period; a whole write runs pre + pilot + space + the 24 bit runs
// and spaces + stop + post ticks. The input side stays ready while a result waits
// as long as the result register can drain into the next free slot.
// ----------------------------------------------------------------------------
// Pulse-width register write transmitter top level
// Input register, waveform engine and result register with valid/ready words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pulse_width_register_write_tx_assert.svh"

module pulse_width_register_write_tx
  import pwrw_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  pwrw_in_if.sink                  in_i,
  pwrw_out_if.source               out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic    in_v_q, in_v_d;
  item_t   in_q;
  logic    out_v_q, out_v_d;
  logic    advance;
  logic    fire;
  logic    in_acc;
  cfg_t    cfg;
  result_t res;

  assign advance   = ~out_v_q | out_o.ready;
  assign fire      = in_v_q & advance;
  assign in_i.ready = ~in_v_q | advance;
  assign in_acc    = in_i.valid & in_i.ready;

  assign in_v_d  = in_acc | (in_v_q & ~fire);
  assign out_v_d = fire | (out_v_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= '{cmd: in_i.cmd, reg_address: in_i.reg_address,
                reg_value: in_i.reg_value, audio_active: in_i.audio_active};
    end
  end

  pwrw_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_e'(cfg_idx_i)),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  pwrw_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_o.valid          = out_v_q;
  assign out_o.select_level   = res.select_level;
  assign out_o.clock_pulse    = res.clock_pulse;
  assign out_o.busy_res       = res.busy_res;
  assign out_o.request_status = res.request_status;
  assign out_o.write_done     = res.write_done;

  `PWRW_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_v_q && !fire, in_v_q, "input word dropped")
  `PWRW_ASSERT_NXT(a_fire_out, clk_i, rst_ni, fire, out_v_q, "result word lost")
  `PWRW_ASSERT_IMP(a_done_tick, clk_i, rst_ni, out_v_q && res.write_done, res.clock_pulse && res.busy_res && (res.request_status == REQ_NONE), "done outside a write tick")
  `PWRW_ASSERT_IMP(a_busy_refuse, clk_i, rst_ni, out_v_q && ((res.request_status == REQ_ACCEPTED) || (res.request_status == REQ_REF_BUSY)), res.busy_res && !res.clock_pulse, "request status without busy")

endmodule

`default_nettype wire

### rtl/core/pwrw_cfg_regs.sv
// ----------------------------------------------------------------------------
// Pulse-width register write transmitter configuration registers
// Address, timing run lengths; written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module pwrw_cfg_regs
  import pwrw_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire cfg_idx_e            idx_i,
  input  wire logic [CfgDataW-1:0] data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_DEV_ADDR: cfg_d.dev_addr = data_i[6:0];
        CFG_PILOT:    cfg_d.pilot    = data_i;
        CFG_ZERO:     cfg_d.zero     = data_i;
        CFG_ONE:      cfg_d.one      = data_i;
        CFG_SPACE:    cfg_d.space    = data_i;
        CFG_STOP:     cfg_d.stop     = data_i;
        CFG_PRE:      cfg_d.pre      = data_i;
        CFG_POST:     cfg_d.post     = data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/pwrw_engine.sv
// ----------------------------------------------------------------------------
// Pulse-width register write transmitter waveform engine
// Phase sequencer, run counter and shift word; registers one result per word.
// ----------------------------------------------------------------------------
`default_nettype none

module pwrw_engine
  import pwrw_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output result_t    res_o
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRE   = 3'd1,
    PH_PILOT = 3'd2,
    PH_BITS  = 3'd3,
    PH_STOP  = 3'd4,
    PH_POST  = 3'd5
  } phase_e;

  localparam logic [BitIdxW-1:0] LastBit = BitIdxW'(WordBits - 1);

  phase_e                phase_q, phase_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [BitIdxW-1:0]    bit_q, bit_d;
  logic [WordBits-1:0]   shift_q, shift_d;
  logic                  space_q, space_d;
  result_t               res_q, res_d;

  logic                  level;
  logic [CntW-1:0]       run_len;
  logic [BitIdxW-1:0]    bit_pos;
  logic                  cur_bit;
  logic                  run_end;

  assign bit_pos = LastBit - bit_q;
  assign cur_bit = shift_q[bit_pos];
  assign run_end = ({1'b0, cnt_q} + {{CntW{1'b0}}, 1'b1}) >= {1'b0, run_len};

  always_comb begin
    unique case (phase_q)
      PH_PILOT, PH_BITS: level = ~space_q;
      PH_STOP:           level = 1'b1;
      default:           level = 1'b0;
    endcase
  end

  always_comb begin
    unique case (phase_q)
      PH_PRE:   run_len = cfg_i.pre;
      PH_PILOT: run_len = space_q ? cfg_i.space : cfg_i.pilot;
      PH_BITS:  run_len = space_q ? cfg_i.space : (cur_bit ? cfg_i.one : cfg_i.zero);
      PH_STOP:  run_len = cfg_i.stop;
      PH_POST:  run_len = cfg_i.post;
      default:  run_len = CntW'(1);
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    space_d = space_q;
    res_d   = res_q;
    if (step_i) begin
      res_d = '{select_level: 1'b0, clock_pulse: 1'b0, busy_res: 1'b0,
                request_status: REQ_NONE, write_done: 1'b0};
      if (item_i.cmd) begin
        priority if (item_i.audio_active) begin
          res_d.request_status = REQ_REF_AUDIO;
          res_d.select_level   = level;
          res_d.busy_res       = (phase_q != PH_IDLE);
        end else if (phase_q != PH_IDLE) begin
          res_d.request_status = REQ_REF_BUSY;
          res_d.select_level   = level;
          res_d.busy_res       = 1'b1;
        end else begin
          res_d.request_status = REQ_ACCEPTED;
          res_d.busy_res       = 1'b1;
          shift_d = {cfg_i.dev_addr, 1'b0, item_i.reg_address, item_i.reg_value};
          phase_d = PH_PRE;
          cnt_d   = '0;
          bit_d   = '0;
          space_d = 1'b0;
        end
      end else if (phase_q != PH_IDLE) begin
        res_d.select_level = level;
        res_d.clock_pulse  = 1'b1;
        res_d.busy_res     = 1'b1;
        if (run_end) begin
          cnt_d = '0;
          unique case (phase_q)
            PH_PRE: begin
              phase_d = PH_PILOT;
              space_d = 1'b0;
            end
            PH_PILOT: begin
              if (!space_q) begin
                space_d = 1'b1;
              end else begin
                phase_d = PH_BITS;
                bit_d   = '0;
                space_d = 1'b0;
              end
            end
            PH_BITS: begin
              priority if (!space_q) begin
                space_d = 1'b1;
              end else if (bit_q >= LastBit) begin
                phase_d = PH_STOP;
                space_d = 1'b0;
              end else begin
                bit_d   = bit_q + BitIdxW'(1);
                space_d = 1'b0;
              end
            end
            PH_STOP: begin
              phase_d = PH_POST;
            end
            default: begin
              phase_d = PH_IDLE;
              bit_d   = '0;
              space_d = 1'b0;
              res_d.write_done = 1'b1;
            end
          endcase
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      space_q <= 1'b0;
      res_q   <= '{select_level: 1'b0, clock_pulse: 1'b0, busy_res: 1'b0,
                   request_status: REQ_NONE, write_done: 1'b0};
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      space_q <= space_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### bench/pulse_width_register_write_tx_tb.sv
// ----------------------------------------------------------------------------
// Pulse-width register write transmitter testbench
// Sends tick and start words through the valid/ready input channel, keeps a
// cycle-free model of the select-line waveform and checks every result word
// in order. Timing registers are changed between bursts, including the
// shortest, zero and longest runs and changes in the middle of a write.
// ----------------------------------------------------------------------------
module pulse_width_register_write_tx_tb;
  import pwrw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE,
    PH_PILOT,
    PH_BITS,
    PH_STOP,
    PH_POST
  } wave_phase_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pwrw_in_if  wr_in ();
  pwrw_out_if wr_out ();

  pulse_width_register_write_tx i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (wr_in),
    .out_o      (wr_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cfg_t        model_cfg = CfgReset;
  wave_phase_e wf_phase  = PH_IDLE;
  logic [7:0]  wf_count  = '0;
  logic [4:0]  wf_bit    = '0;
  logic [23:0] wf_word   = '0;
  logic        wf_space  = 1'b0;

  item_t       command_q[$];
  result_t     line_states_q[$];
  int unsigned burst_max = 7;
  int unsigned mismatch_count = 0;

  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned stall_left;
  logic        offering;
  item_t       next_word;
  result_t     seen;
  result_t     want;

  function automatic logic line_level();
    case (wf_phase)
      PH_PILOT, PH_BITS: return !wf_space;
      PH_STOP:           return 1'b1;
      default:           return 1'b0;
    endcase
  endfunction

  function automatic result_t advance_waveform(item_t w);
    result_t     r;
    int unsigned run;
    logic        bit_now;
    r = '0;
    r.request_status = REQ_NONE;
    if (w.cmd) begin
      if (w.audio_active) begin
        r.request_status = REQ_REF_AUDIO;
      end else if (wf_phase != PH_IDLE) begin
        r.request_status = REQ_REF_BUSY;
      end else begin
        r.request_status = REQ_ACCEPTED;
        wf_word  = {model_cfg.dev_addr, 1'b0, w.reg_address, w.reg_value};
        wf_phase = PH_PRE;
        wf_count = '0;
        wf_bit   = '0;
        wf_space = 1'b0;
      end
      r.select_level = line_level();
      r.busy_res     = (wf_phase != PH_IDLE);
    end else if (wf_phase != PH_IDLE) begin
      r.select_level = line_level();
      r.clock_pulse  = 1'b1;
      r.busy_res     = 1'b1;
      bit_now = wf_word[WordBits - 1 - wf_bit];
      case (wf_phase)
        PH_PRE:   run = model_cfg.pre;
        PH_PILOT: run = wf_space ? model_cfg.space : model_cfg.pilot;
        PH_BITS:  run = wf_space ? model_cfg.space : (bit_now ? model_cfg.one : model_cfg.zero);
        PH_STOP:  run = model_cfg.stop;
        PH_POST:  run = model_cfg.post;
        default:  run = 1;
      endcase
      if (wf_count + 1 >= run) begin
        wf_count = '0;
        case (wf_phase)
          PH_PRE: begin
            wf_phase = PH_PILOT;
            wf_space = 1'b0;
          end
          PH_PILOT: begin
            if (!wf_space) begin
              wf_space = 1'b1;
            end else begin
              wf_phase = PH_BITS;
              wf_bit   = '0;
              wf_space = 1'b0;
            end
          end
          PH_BITS: begin
            if (!wf_space) begin
              wf_space = 1'b1;
            end else if (wf_bit >= WordBits - 1) begin
              wf_phase = PH_STOP;
              wf_space = 1'b0;
            end else begin
              wf_bit   = wf_bit + 1;
              wf_space = 1'b0;
            end
          end
          PH_STOP: begin
            wf_phase = PH_POST;
          end
          default: begin
            wf_phase     = PH_IDLE;
            wf_bit       = '0;
            wf_space     = 1'b0;
            r.write_done = 1'b1;
          end
        endcase
      end else begin
        wf_count = wf_count + 1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_in.valid        <= 1'b0;
      wr_in.cmd          <= 1'b0;
      wr_in.reg_address  <= '0;
      wr_in.reg_value    <= '0;
      wr_in.audio_active <= 1'b0;
      send_gap           <= 0;
    end else begin
      offering = wr_in.valid;
      if (wr_in.valid && wr_in.ready) begin
        line_states_q.push_back(advance_waveform(item_t'{wr_in.cmd, wr_in.reg_address,
                                                          wr_in.reg_value,
                                                          wr_in.audio_active}));
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (command_q.size() != 0) begin
          next_word = command_q.pop_front();
          wr_in.cmd          <= next_word.cmd;
          wr_in.reg_address  <= next_word.reg_address;
          wr_in.reg_value    <= next_word.reg_value;
          wr_in.audio_active <= next_word.audio_active;
          send_gap           <= $urandom_range(0, burst_max);
          offering = 1'b1;
        end
      end
      wr_in.valid <= offering;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_out.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      stall_left = recv_stall;
      if (wr_out.valid && wr_out.ready) begin
        seen = '{wr_out.select_level, wr_out.clock_pulse, wr_out.busy_res,
                 req_status_e'(wr_out.request_status), wr_out.write_done};
        if (line_states_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual sel=%0b clk=%0b busy=%0b st=%0d done=%0b",
                   $time, seen.select_level, seen.clock_pulse, seen.busy_res,
                   seen.request_status, seen.write_done);
          mismatch_count++;
        end else begin
          want = line_states_q.pop_front();
          if (seen !== want) begin
            $display("%0t: expected sel=%0b clk=%0b busy=%0b st=%0d done=%0b, actual sel=%0b clk=%0b busy=%0b st=%0d done=%0b",
                     $time, want.select_level, want.clock_pulse, want.busy_res,
                     want.request_status, want.write_done, seen.select_level,
                     seen.clock_pulse, seen.busy_res, seen.request_status,
                     seen.write_done);
            mismatch_count++;
          end
        end
        stall_left = $urandom_range(0, burst_max);
      end
      if (stall_left != 0) begin
        wr_out.ready <= 1'b0;
        recv_stall   <= stall_left - 1;
      end else begin
        wr_out.ready <= 1'b1;
        recv_stall   <= 0;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  task automatic apply_config(cfg_t c);
    model_cfg = c;
    write_reg(CFG_DEV_ADDR, {1'($urandom), c.dev_addr});
    write_reg(CFG_PILOT, c.pilot);
    write_reg(CFG_ZERO, c.zero);
    write_reg(CFG_ONE, c.one);
    write_reg(CFG_SPACE, c.space);
    write_reg(CFG_STOP, c.stop);
    write_reg(CFG_PRE, c.pre);
    write_reg(CFG_POST, c.post);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (command_q.size() != 0 || wr_in.valid || line_states_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic push_word(logic cmd, logic [7:0] ra, logic [7:0] rv, logic audio);
    command_q.push_back(item_t'{cmd, ra, rv, audio});
  endtask

  task automatic push_ticks(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      push_word(1'b0, 8'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic push_traffic(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      push_word($urandom_range(0, 15) == 0, 8'($urandom), 8'($urandom),
                $urandom_range(0, 3) == 0);
    end
  endtask

  function automatic logic [7:0] draw_run_len();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(5, 255));
    return 8'($urandom_range(0, 4));
  endfunction

  function automatic cfg_t uniform_cfg(logic [6:0] dev, logic [7:0] len);
    return '{dev_addr: dev, pilot: len, zero: len, one: len, space: len,
             stop: len, pre: len, post: len};
  endfunction

  initial begin : stimulus
    cfg_t c;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_DEV_ADDR;
    cfg_data_i         = '0;
    wr_in.valid        = 1'b0;
    wr_in.cmd          = 1'b0;
    wr_in.reg_address  = '0;
    wr_in.reg_value    = '0;
    wr_in.audio_active = 1'b0;
    wr_out.ready       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle ticks, refusals in both orders, one accepted start
    push_word(1'b0, 8'hFF, 8'hFF, 1'b1);
    push_word(1'b0, 8'h00, 8'h00, 1'b0);
    push_word(1'b1, 8'h00, 8'h00, 1'b1);
    push_word(1'b1, 8'hFF, 8'h00, 1'b0);
    push_word(1'b1, 8'h00, 8'hFF, 1'b0);
    push_word(1'b1, 8'hFF, 8'hFF, 1'b1);
    push_ticks(15);
    wait_drained();

    // shrink every run to one tick in the middle of the write
    burst_max = 0;
    apply_config(uniform_cfg(7'h7F, 8'd1));
    push_ticks(100);
    push_word(1'b1, 8'h00, 8'hFF, 1'b0);
    push_ticks(60);
    wait_drained();

    burst_max = 7;
    apply_config(uniform_cfg(7'h00, 8'd0));
    push_word(1'b1, 8'hA5, 8'h5A, 1'b0);
    push_ticks(60);
    wait_drained();

    c = uniform_cfg(7'h2A, 8'd1);
    c.zero = 8'd255;
    c.one  = 8'd255;
    apply_config(c);
    push_word(1'b1, 8'hC3, 8'h3C, 1'b0);
    push_ticks(300);
    wait_drained();

    burst_max = 0;
    c.zero = 8'd2;
    c.one  = 8'd2;
    c.stop = 8'd40;
    c.post = 8'd40;
    apply_config(c);
    push_ticks(200);
    wait_drained();

    burst_max = 7;
    c = uniform_cfg(7'h53, 8'd1);
    c.pre   = 8'd255;
    c.pilot = 8'd255;
    c.space = 8'd255;
    apply_config(c);
    push_word(1'b1, 8'h55, 8'hAA, 1'b0);
    push_ticks(300);
    wait_drained();

    for (int unsigned p = 0; p < 8; p++) begin
      burst_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      c.dev_addr = 7'($urandom);
      c.pilot    = draw_run_len();
      c.zero     = draw_run_len();
      c.one      = draw_run_len();
      c.space    = draw_run_len();
      c.stop     = draw_run_len();
      c.pre      = draw_run_len();
      c.post     = draw_run_len();
      apply_config(c);
      push_traffic(70);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/pwrw_pkg.sv
rtl/core/pwrw_if.sv
rtl/core/pwrw_cfg_regs.sv
rtl/core/pwrw_engine.sv
rtl/core/pulse_width_register_write_tx.sv
bench/pulse_width_register_write_tx_tb.sv
